// ===== rtl/core/bsc_pkg.sv =====
// Shared types, register indexes and arithmetic helpers for the barometric compensation block.
package bsc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } bsc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               status;
  } bsc_out_t;

  typedef enum logic [2:0] {
    REG_AC1_AC2_AC3 = 3'd0,
    REG_AC4_AC5_AC6 = 3'd1,
    REG_B1_B2       = 3'd2,
    REG_MC_MD       = 3'd3,
    REG_OSS         = 3'd4
  } bsc_reg_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // Signed division by 2^k, truncating toward zero.
  function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] a,
                                                   input int unsigned k);
    logic signed [31:0] bias;
    bias = a[31] ? signed'(32'((64'd1 << k) - 64'd1)) : 32'sd0;
    return (a + bias) >>> k;
  endfunction

  // Low 32 bits of a product; identical for signed and unsigned operands.
  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

endpackage

// ===== rtl/core/bsc_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
module bsc_div #(
  parameter int unsigned W    = 32,
  parameter int unsigned SB_W = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [W-1:0]    in_num,
  input  logic [W-1:0]    in_den,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_vld,
  output logic [W-1:0]    out_quo,
  output logic [SB_W-1:0] out_sb
);
  import bsc_pkg::*;

  logic [W-1:0]    rem_r [W];
  logic [W-1:0]    quo_r [W];
  logic [W-1:0]    den_r [W];
  logic [SB_W-1:0] sb_r  [W];
  logic [W-1:0]    vld_r;

  logic [W-1:0]    rem_nxt [W];
  logic [W-1:0]    quo_nxt [W];
  logic [W-1:0]    den_nxt [W];
  logic [SB_W-1:0] sb_nxt  [W];
  logic [W-1:0]    vld_nxt;

  always_comb begin
    logic [W-1:0] rem_s;
    logic [W-1:0] quo_s;
    logic [W:0]   trial;
    logic         ge;
    for (int k = 0; k < W; k++) begin
      rem_s      = (k == 0) ? '0 : rem_r[k-1];
      quo_s      = (k == 0) ? in_num : quo_r[k-1];
      den_nxt[k] = (k == 0) ? in_den : den_r[k-1];
      sb_nxt[k]  = (k == 0) ? in_sb : sb_r[k-1];
      vld_nxt[k] = (k == 0) ? in_vld : vld_r[k-1];
      trial      = {rem_s, quo_s[W-1]};
      ge         = (trial >= {1'b0, den_nxt[k]});
      rem_nxt[k] = ge ? W'(trial - {1'b0, den_nxt[k]}) : trial[W-1:0];
      quo_nxt[k] = {quo_s[W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < W; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_nxt[k];
        sb_r[k]  <= sb_nxt[k];
      end
    end
  end

  assign out_vld = vld_r[W-1];
  assign out_quo = quo_r[W-1];
  assign out_sb  = sb_r[W-1];

endmodule

// ===== rtl/core/barometric_sensor_compensation.sv =====
// Top level of the barometric temperature and pressure compensation pipeline.
// One item enters per cycle unless the output stalls; the two 32-stage
// dividers (temperature and pressure divisors) make up most of the stages.
// Any stall on the result side freezes the whole pipeline, so in_ready is low
// exactly when a result waits and out_ready is low. A zero divisor gives
// status 1 with both value fields zero. Calibration is read live where used.
module barometric_sensor_compensation (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bsc_pkg::bsc_in_t                    in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bsc_pkg::bsc_out_t                   out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bsc_pkg::*;

  // Calibration registers.
  logic [47:0] cal0_r, cal1_r;
  logic [31:0] cal2_r, cal3_r;
  logic [1:0]  oss_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal0_r <= '0;
      cal1_r <= '0;
      cal2_r <= '0;
      cal3_r <= '0;
      oss_r  <= '0;
    end else if (cfg_valid) begin
      case (bsc_reg_t'(cfg_index))
        REG_AC1_AC2_AC3: cal0_r <= cfg_data[47:0];
        REG_AC4_AC5_AC6: cal1_r <= cfg_data[47:0];
        REG_B1_B2:       cal2_r <= cfg_data[31:0];
        REG_MC_MD:       cal3_r <= cfg_data[31:0];
        REG_OSS:         oss_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0] ac4, ac5, ac6;
  assign ac1 = {{16{cal0_r[47]}}, cal0_r[47:32]};
  assign ac2 = {{16{cal0_r[31]}}, cal0_r[31:16]};
  assign ac3 = {{16{cal0_r[15]}}, cal0_r[15:0]};
  assign ac4 = cal1_r[47:32];
  assign ac5 = cal1_r[31:16];
  assign ac6 = cal1_r[15:0];
  assign b1  = {{16{cal2_r[31]}}, cal2_r[31:16]};
  assign b2  = {{16{cal2_r[15]}}, cal2_r[15:0]};
  assign mc  = {{16{cal3_r[31]}}, cal3_r[31:16]};
  assign md  = {{16{cal3_r[15]}}, cal3_r[15:0]};

  logic adv;
  logic out_valid_r;
  bsc_out_t out_item_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stage valid bits.
  logic s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;
  logic s7_vld_r, s8_vld_r, s9_vld_r, s10_vld_r, s11_vld_r, s12_vld_r, s13_vld_r;
  logic s14_vld_r, s15_vld_r, s16_vld_r, s17_vld_r;
  logic d1_vld, d2_vld;

  // Stage 0: input capture and pressure alignment.
  logic [15:0] s0_ut_r;
  logic [23:0] s0_up_r;
  // Stage 1: first temperature product.
  logic [31:0] s1_prod_r;
  logic [23:0] s1_up_r;
  // Stage 2: X1 and the divisor.
  logic signed [31:0] s2_x1_r, s2_dvs_r, s2_num_r;
  logic [23:0] s2_up_r;
  // Stage 3: magnitudes for the divider.
  logic [31:0] s3_an_r, s3_ad_r;
  logic signed [31:0] s3_x1_r;
  logic [23:0] s3_up_r;
  logic s3_neg_r, s3_dz_r;

  logic [57:0] d1_sb_in, d1_sb;
  logic [31:0] d1_quo;

  logic signed [31:0] s4_b5_r;
  logic [23:0] s4_up_r;
  logic s4_dz_r;
  logic signed [15:0] s5_t_r;
  logic signed [31:0] s5_b6_r;
  logic [23:0] s5_up_r;
  logic s5_dz_r;
  logic signed [31:0] s6_m66_r, s6_mac2_r, s6_mac3_r;
  logic signed [15:0] s6_t_r;
  logic [23:0] s6_up_r;
  logic s6_dz_r;
  logic signed [31:0] s7_s66_r, s7_x2a_r, s7_x1c_r;
  logic signed [15:0] s7_t_r;
  logic [23:0] s7_up_r;
  logic s7_dz_r;
  logic signed [31:0] s8_mb2_r, s8_mb1_r, s8_x2a_r, s8_x1c_r;
  logic signed [15:0] s8_t_r;
  logic [23:0] s8_up_r;
  logic s8_dz_r;
  logic signed [31:0] s9_x3_r, s9_x3c_r;
  logic signed [15:0] s9_t_r;
  logic [23:0] s9_up_r;
  logic s9_dz_r;
  logic signed [31:0] s10_v_r, s10_w_r;
  logic signed [15:0] s10_t_r;
  logic [23:0] s10_up_r;
  logic s10_dz_r;
  logic signed [31:0] s11_b3_r, s11_x3d_r;
  logic signed [15:0] s11_t_r;
  logic [23:0] s11_up_r;
  logic s11_dz_r;
  logic [31:0] s12_pb4_r, s12_pb7_r;
  logic signed [15:0] s12_t_r;
  logic s12_dz_r;
  logic [31:0] s13_num_r, s13_den_r;
  logic signed [15:0] s13_t_r;
  logic s13_big_r, s13_zero_r;

  logic [17:0] d2_sb_in, d2_sb;
  logic [31:0] d2_quo;

  logic signed [31:0] s14_p_r;
  logic signed [15:0] s14_t_r;
  logic s14_zero_r;
  logic signed [31:0] s15_x1m_r, s15_mp_r, s15_p_r;
  logic signed [15:0] s15_t_r;
  logic s15_zero_r;
  logic signed [31:0] s16_x1_r, s16_x2_r, s16_p_r;
  logic signed [15:0] s16_t_r;
  logic s16_zero_r;
  logic signed [31:0] s17_s_r, s17_p_r;
  logic signed [15:0] s17_t_r;
  logic s17_zero_r;

  // Combinational next values that need more than one line.
  logic signed [31:0] x1_nxt, b5_nxt, tq_nxt, b6_nxt, p_nxt, d8_nxt, pf_nxt;
  logic signed [15:0] t_nxt;
  logic [16:0] ut_m_nxt;
  logic [31:0] pb4_nxt, pb7_nxt, b4_nxt;

  assign ut_m_nxt = {1'b0, s0_ut_r} - {1'b0, ac6};
  assign x1_nxt   = sdiv_pow2(signed'(s1_prod_r), 15);
  assign b5_nxt   = signed'(d1_sb[57:26]) + (d1_sb[1] ? -signed'(d1_quo) : signed'(d1_quo));
  assign tq_nxt   = sdiv_pow2(s4_b5_r + 32'sd8, 4);
  assign b6_nxt   = s4_b5_r - 32'sd4000;
  assign pb4_nxt  = mul_lo({16'd0, ac4}, s11_x3d_r);
  assign pb7_nxt  = mul_lo({8'd0, s11_up_r} - s11_b3_r, 32'(17'd50000 >> oss_r));
  assign b4_nxt   = s12_pb4_r >> 15;
  assign p_nxt    = d2_sb[17] ? signed'({d2_quo[30:0], 1'b0}) : signed'(d2_quo);
  assign d8_nxt   = sdiv_pow2(s14_p_r, 8);
  assign pf_nxt   = s17_p_r + sdiv_pow2(s17_s_r, 4);

  always_comb begin
    if (tq_nxt > 32'sd32767) begin
      t_nxt = 16'sh7fff;
    end else if (tq_nxt < -32'sd32768) begin
      t_nxt = 16'sh8000;
    end else begin
      t_nxt = tq_nxt[15:0];
    end
  end

  // Sideband: x1, up, neg, dz.
  assign d1_sb_in = {s3_x1_r, s3_up_r, s3_neg_r, s3_dz_r};
  // Sideband: big, zero, t.
  assign d2_sb_in = {s13_big_r, s13_zero_r, s13_t_r};

  bsc_div #(.W(32), .SB_W(58)) u_div_t (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s3_vld_r),
    .in_num  (s3_an_r),
    .in_den  (s3_ad_r),
    .in_sb   (d1_sb_in),
    .out_vld (d1_vld),
    .out_quo (d1_quo),
    .out_sb  (d1_sb)
  );

  bsc_div #(.W(32), .SB_W(18)) u_div_p (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s13_vld_r),
    .in_num  (s13_num_r),
    .in_den  (s13_den_r),
    .in_sb   (d2_sb_in),
    .out_vld (d2_vld),
    .out_quo (d2_quo),
    .out_sb  (d2_sb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0; s1_vld_r <= 1'b0; s2_vld_r <= 1'b0; s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0; s5_vld_r <= 1'b0; s6_vld_r <= 1'b0; s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0; s9_vld_r <= 1'b0; s10_vld_r <= 1'b0; s11_vld_r <= 1'b0;
      s12_vld_r <= 1'b0; s13_vld_r <= 1'b0; s14_vld_r <= 1'b0; s15_vld_r <= 1'b0;
      s16_vld_r <= 1'b0; s17_vld_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r    <= in_valid;
      s1_vld_r    <= s0_vld_r;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= d1_vld;
      s5_vld_r    <= s4_vld_r;
      s6_vld_r    <= s5_vld_r;
      s7_vld_r    <= s6_vld_r;
      s8_vld_r    <= s7_vld_r;
      s9_vld_r    <= s8_vld_r;
      s10_vld_r   <= s9_vld_r;
      s11_vld_r   <= s10_vld_r;
      s12_vld_r   <= s11_vld_r;
      s13_vld_r   <= s12_vld_r;
      s14_vld_r   <= d2_vld;
      s15_vld_r   <= s14_vld_r;
      s16_vld_r   <= s15_vld_r;
      s17_vld_r   <= s16_vld_r;
      out_valid_r <= s17_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ut_r <= in_item.raw_temperature;
      s0_up_r <= in_item.raw_pressure >> (4'd8 - {2'b00, oss_r});

      s1_prod_r <= mul_lo({{15{ut_m_nxt[16]}}, ut_m_nxt}, {16'd0, ac5});
      s1_up_r   <= s0_up_r;

      s2_x1_r  <= x1_nxt;
      s2_dvs_r <= x1_nxt + md;
      s2_num_r <= mc <<< 11;
      s2_up_r  <= s1_up_r;

      // A zero divisor is replaced by one; the flag zeroes the result later.
      s3_dz_r  <= (s2_dvs_r == 32'sd0);
      s3_neg_r <= s2_num_r[31] ^ s2_dvs_r[31];
      s3_an_r  <= abs32(s2_num_r);
      s3_ad_r  <= (s2_dvs_r == 32'sd0) ? 32'd1 : abs32(s2_dvs_r);
      s3_x1_r  <= s2_x1_r;
      s3_up_r  <= s2_up_r;

      s4_b5_r <= b5_nxt;
      s4_up_r <= d1_sb[25:2];
      s4_dz_r <= d1_sb[0];

      s5_t_r  <= t_nxt;
      s5_b6_r <= b6_nxt;
      s5_up_r <= s4_up_r;
      s5_dz_r <= s4_dz_r;

      s6_m66_r  <= mul_lo(s5_b6_r, s5_b6_r);
      s6_mac2_r <= mul_lo(ac2, s5_b6_r);
      s6_mac3_r <= mul_lo(ac3, s5_b6_r);
      s6_t_r    <= s5_t_r;
      s6_up_r   <= s5_up_r;
      s6_dz_r   <= s5_dz_r;

      s7_s66_r <= sdiv_pow2(s6_m66_r, 12);
      s7_x2a_r <= sdiv_pow2(s6_mac2_r, 11);
      s7_x1c_r <= sdiv_pow2(s6_mac3_r, 13);
      s7_t_r   <= s6_t_r;
      s7_up_r  <= s6_up_r;
      s7_dz_r  <= s6_dz_r;

      s8_mb2_r <= mul_lo(b2, s7_s66_r);
      s8_mb1_r <= mul_lo(b1, s7_s66_r);
      s8_x2a_r <= s7_x2a_r;
      s8_x1c_r <= s7_x1c_r;
      s8_t_r   <= s7_t_r;
      s8_up_r  <= s7_up_r;
      s8_dz_r  <= s7_dz_r;

      s9_x3_r  <= sdiv_pow2(s8_mb2_r, 11) + s8_x2a_r;
      s9_x3c_r <= s8_x1c_r + sdiv_pow2(s8_mb1_r, 16);
      s9_t_r   <= s8_t_r;
      s9_up_r  <= s8_up_r;
      s9_dz_r  <= s8_dz_r;

      s10_v_r  <= ((ac1 <<< 2) + s9_x3_r) << oss_r;
      s10_w_r  <= s9_x3c_r + 32'sd2;
      s10_t_r  <= s9_t_r;
      s10_up_r <= s9_up_r;
      s10_dz_r <= s9_dz_r;

      s11_b3_r  <= sdiv_pow2(s10_v_r + 32'sd2, 2);
      s11_x3d_r <= sdiv_pow2(s10_w_r, 2) + 32'sd32768;
      s11_t_r   <= s10_t_r;
      s11_up_r  <= s10_up_r;
      s11_dz_r  <= s10_dz_r;

      s12_pb4_r <= pb4_nxt;
      s12_pb7_r <= pb7_nxt;
      s12_t_r   <= s11_t_r;
      s12_dz_r  <= s11_dz_r;

      // A large B7 is divided first and doubled afterward.
      s13_big_r  <= s12_pb7_r[31];
      s13_num_r  <= s12_pb7_r[31] ? s12_pb7_r : {s12_pb7_r[30:0], 1'b0};
      s13_den_r  <= (b4_nxt == 32'd0) ? 32'd1 : b4_nxt;
      s13_zero_r <= s12_dz_r || (b4_nxt == 32'd0);
      s13_t_r    <= s12_t_r;

      s14_p_r    <= p_nxt;
      s14_zero_r <= d2_sb[16];
      s14_t_r    <= d2_sb[15:0];

      s15_x1m_r  <= mul_lo(d8_nxt, d8_nxt);
      s15_mp_r   <= mul_lo(-32'sd7357, s14_p_r);
      s15_p_r    <= s14_p_r;
      s15_t_r    <= s14_t_r;
      s15_zero_r <= s14_zero_r;

      s16_x1_r   <= mul_lo(s15_x1m_r, 32'sd3038);
      s16_x2_r   <= sdiv_pow2(s15_mp_r, 16);
      s16_p_r    <= s15_p_r;
      s16_t_r    <= s15_t_r;
      s16_zero_r <= s15_zero_r;

      s17_s_r    <= sdiv_pow2(s16_x1_r, 16) + s16_x2_r + 32'sd3791;
      s17_p_r    <= s16_p_r;
      s17_t_r    <= s16_t_r;
      s17_zero_r <= s16_zero_r;

      out_item_r.status             <= s17_zero_r;
      out_item_r.temperature_tenths <= s17_zero_r ? 16'sd0 : s17_t_r;
      out_item_r.pressure_pa        <= s17_zero_r ? 32'sd0 : pf_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |->
      out_item.temperature_tenths == 16'sd0 && out_item.pressure_pa == 32'sd0)
    else $error("status set with nonzero result fields");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
